@@ design/kbit_pkg.sv @@
// ----------------------------------------------------------------------------
// kbit_pkg
// Types and constants shared by the button grading and knob slider block.
// ----------------------------------------------------------------------------
`default_nettype none

package kbit_pkg;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_ACK  = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		GRADE_NONE  = 3'd0,
		GRADE_SHORT = 3'd1,
		GRADE_MID   = 3'd2,
		GRADE_MID2  = 3'd3,
		GRADE_LONG  = 3'd4
	} grade_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_SLIDER_ACTIVE = 1'b0,
		CFG_SLIDER_SPAN   = 1'b1
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned POS_W      = 17;
	localparam int unsigned HOLD_W     = 5;
	localparam int unsigned DIM_W      = 3;

	localparam logic [POS_W-1:0]  WINDOW_OFFSET = 17'd256;

	localparam logic [HOLD_W-1:0] HOLD_SHORT = 5'd5;
	localparam logic [HOLD_W-1:0] HOLD_MID   = 5'd10;
	localparam logic [HOLD_W-1:0] HOLD_MID2  = 5'd15;
	localparam logic [HOLD_W-1:0] HOLD_LONG  = 5'd20;
	localparam logic [HOLD_W-1:0] HOLD_MAX   = 5'd31;

	localparam logic [DIM_W-1:0]  DIM_LENGTH = 3'd2;
	localparam logic [DIM_W-1:0]  DIM_RESET  = 3'd5;

	localparam logic [1:0] LEVEL_ONE   = 2'd1;
	localparam logic [1:0] LEVEL_TWO   = 2'd2;
	localparam logic [1:0] LEVEL_THREE = 2'd3;

	typedef struct packed {
		command_t         command;
		logic             button_level;
		logic             knob_moving;
		logic [POS_W-1:0] encoder_position;
	} item_t;

	typedef struct packed {
		grade_t           press_grade;
		grade_t           released_grade;
		logic [1:0]       press_level;
		logic [15:0]      activity_count;
		logic [POS_W-1:0] clamped_position;
		logic [15:0]      slider_offset;
		logic             position_write;
		logic             backlight_dim;
	} result_t;

endpackage

`default_nettype wire

@@ design/kbit_core.sv @@
// ----------------------------------------------------------------------------
// kbit_core
// Press grading, activity count, backlight dim and slider clamp state.
// ----------------------------------------------------------------------------
`default_nettype none

module kbit_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire kbit_pkg::cfg_index_t            cfg_index,
	input  wire logic [kbit_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            advance,
	input  wire kbit_pkg::item_t                 item_s1,
	output kbit_pkg::result_t                    result_n
);
	import kbit_pkg::*;

	logic              slider_active_q;
	logic [15:0]       slider_span_q;
	logic [HOLD_W-1:0] hold_q;
	grade_t            grade_q;
	grade_t            released_q;
	logic              prev_level_q;
	logic [1:0]        level_q;
	logic [15:0]       activity_q;
	logic [DIM_W-1:0]  dim_q;

	logic [HOLD_W-1:0] hold_a, hold_n;
	grade_t            grade_a, grade_n, released_n;
	logic [1:0]        level_a, level_n;
	logic [15:0]       activity_n;
	logic [DIM_W-1:0]  dim_base, dim_n;
	logic              dim;
	logic              pressed;
	logic              hold_over;
	logic [POS_W-1:0]  window_hi, pos_c;
	logic              pos_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slider_active_q <= 1'b0;
			slider_span_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLIDER_ACTIVE: slider_active_q <= cfg_data[0];
				CFG_SLIDER_SPAN:   slider_span_q   <= cfg_data[15:0];
				default:           slider_span_q   <= slider_span_q;
			endcase
		end
	end

	assign pressed   = !item_s1.button_level;
	assign hold_over = hold_q > HOLD_LONG;
	assign hold_a    = hold_over ? '0 : hold_q;
	assign grade_a   = hold_over ? GRADE_LONG : grade_q;
	assign level_a   = hold_over ? LEVEL_TWO : level_q;
	assign window_hi = WINDOW_OFFSET + {1'b0, slider_span_q};

	// Slider window clamp; the window always holds at least its lower edge.
	always_comb begin
		pos_c     = item_s1.encoder_position;
		pos_write = 1'b0;
		if (slider_active_q) begin
			if (item_s1.encoder_position < WINDOW_OFFSET) begin
				pos_c     = WINDOW_OFFSET;
				pos_write = 1'b1;
			end else if (item_s1.encoder_position > window_hi) begin
				pos_c     = window_hi;
				pos_write = 1'b1;
			end
		end
	end

	always_comb begin
		grade_n    = grade_a;
		level_n    = level_a;
		released_n = released_q;
		hold_n     = hold_a;
		if (pressed) begin
			priority if (hold_a > HOLD_LONG) begin
				grade_n = GRADE_LONG;
				level_n = LEVEL_THREE;
			end else if (hold_a > HOLD_MID2) begin
				grade_n = GRADE_MID2;
				level_n = LEVEL_TWO;
			end else if (hold_a > HOLD_MID) begin
				grade_n = GRADE_MID;
				level_n = LEVEL_ONE;
			end else if (hold_a > HOLD_SHORT) begin
				grade_n = GRADE_SHORT;
			end
			if (hold_a != HOLD_MAX)
				hold_n = hold_a + 1'b1;
		end else begin
			if (!prev_level_q)
				released_n = grade_a;
			grade_n = GRADE_NONE;
			hold_n  = '0;
		end
	end

	assign activity_n = activity_q + {15'd0, item_s1.knob_moving} + {15'd0, pressed};

	always_comb begin
		dim_base = dim_q;
		if (hold_n == HOLD_SHORT || hold_n == HOLD_MID ||
		    hold_n == HOLD_MID2 || hold_n == HOLD_LONG)
			dim_base = DIM_LENGTH;
	end
	assign dim   = dim_base != '0;
	assign dim_n = dim ? dim_base - 1'b1 : dim_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q       <= '0;
			grade_q      <= GRADE_NONE;
			released_q   <= GRADE_NONE;
			prev_level_q <= 1'b0;
			level_q      <= '0;
			activity_q   <= '0;
			dim_q        <= DIM_RESET;
		end else if (advance) begin
			if (item_s1.command == CMD_ACK) begin
				grade_q    <= GRADE_NONE;
				released_q <= GRADE_NONE;
			end else begin
				hold_q       <= hold_n;
				grade_q      <= grade_n;
				released_q   <= released_n;
				prev_level_q <= item_s1.button_level;
				level_q      <= level_n;
				activity_q   <= activity_n;
				dim_q        <= dim_n;
			end
		end
	end

	always_comb begin
		if (item_s1.command == CMD_ACK) begin
			result_n.press_grade      = GRADE_NONE;
			result_n.released_grade   = GRADE_NONE;
			result_n.press_level      = level_q;
			result_n.activity_count   = activity_q;
			result_n.clamped_position = '0;
			result_n.slider_offset    = '0;
			result_n.position_write   = 1'b0;
			result_n.backlight_dim    = 1'b0;
		end else begin
			result_n.press_grade      = grade_n;
			result_n.released_grade   = released_n;
			result_n.press_level      = level_n;
			result_n.activity_count   = activity_n;
			result_n.clamped_position = slider_active_q ? pos_c : item_s1.encoder_position;
			result_n.slider_offset    = slider_active_q ? 16'(pos_c - WINDOW_OFFSET) : 16'd0;
			result_n.position_write   = pos_write;
			result_n.backlight_dim    = dim;
		end
	end

`ifndef SYNTH
	// The hold count is cleared once it passes the long threshold.
	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q <= HOLD_LONG + 5'd1)
		else $error("hold count beyond long threshold plus one");

	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == CMD_ACK |=>
			grade_q == GRADE_NONE && released_q == GRADE_NONE)
		else $error("acknowledge did not clear the grades");

	a_dim_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == CMD_TICK && hold_n == HOLD_SHORT |=>
			dim_q == DIM_LENGTH - 3'd1)
		else $error("dim not started at the short threshold");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(activity_q) && $stable(hold_q) && $stable(dim_q))
		else $error("state changed without a transfer");
`endif

endmodule

`default_nettype wire

@@ design/kbit_out_reg.sv @@
// ----------------------------------------------------------------------------
// kbit_out_reg
// Result register with valid and stall towards the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module kbit_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pending,
	input  wire kbit_pkg::result_t result_n,
	input  wire logic              result_stall,
	output logic                   ready,
	output logic                   result_valid,
	output kbit_pkg::result_t      result
);
	import kbit_pkg::*;

	logic    valid_q;
	result_t result_q;

	// The register takes a new result when it is empty or its content leaves.
	assign ready = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= pending;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && pending) begin
			result_q <= result_n;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ design/knob_button_input_tick.sv @@
// ----------------------------------------------------------------------------
// knob_button_input_tick
// Button press grading, activity count, backlight dim and knob slider clamp.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  item      item_valid / item_stall      item   (kbit_pkg::item_t)
//  result    result_valid / result_stall  result (kbit_pkg::result_t)
//  config    cfg_we                       cfg_index, cfg_data
//
//  An item is registered in the input register on transfer and its result in
//  the result register; one item is taken every cycle while item_stall is low.
//  The result register is the only point of back-pressure: item_stall rises
//  only while an item waits in the input register and the result is stalled.
//  Reset clears control state but not data; the dim countdown starts at five.
// ----------------------------------------------------------------------------
`default_nettype none

module knob_button_input_tick (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire kbit_pkg::item_t                 item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output kbit_pkg::result_t                    result,
	input  wire logic                            cfg_we,
	input  wire kbit_pkg::cfg_index_t            cfg_index,
	input  wire logic [kbit_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kbit_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    out_ready;
	logic    advance;
	logic    accept;
	result_t result_n;

	assign advance    = valid_s1 && out_ready;
	assign item_stall = valid_s1 && !out_ready;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	kbit_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (advance),
		.item_s1  (item_s1),
		.result_n (result_n)
	);

	kbit_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.pending     (valid_s1),
		.result_n    (result_n),
		.result_stall(result_stall),
		.ready       (out_ready),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

`default_nettype wire
